>>> rtl/hld_pkg.sv
`default_nettype none

package hld_pkg;

    localparam int MAX_LABEL = 256;
    localparam int HUB_BITS  = 23;
    localparam int DIST_BITS = 32;

    // result width is fixed by the 25.8 output format
    localparam int SUM_BITS  = 33;
    localparam int ADD_BITS  = DIST_BITS + 1;
    localparam int WIDE_BITS = (ADD_BITS > SUM_BITS) ? ADD_BITS : SUM_BITS;

    localparam int ADDR_BITS = $clog2(MAX_LABEL);
    localparam int CNT_BITS  = $clog2(MAX_LABEL + 1);
    localparam int ENTRY_BITS = HUB_BITS + DIST_BITS;

    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    typedef enum logic [1:0] {
        KIND_LOAD       = 2'd0,
        KIND_PROBE      = 2'd1,
        KIND_PROBE_LAST = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [HUB_BITS-1:0]   hub;
        logic [DIST_BITS-1:0]  hop_dist;
        logic                  last;
    } t_qitem;

    // add two distances and clamp at the largest result value
    function automatic logic [SUM_BITS-1:0] sat_sum(input logic [DIST_BITS-1:0] a,
                                                    input logic [DIST_BITS-1:0] b);
        logic [WIDE_BITS-1:0] s;
        logic [WIDE_BITS-1:0] lim;
        s   = WIDE_BITS'(a) + WIDE_BITS'(b);
        lim = WIDE_BITS'(SUM_MAX);
        if (s > lim) begin
            return SUM_MAX;
        end
        return SUM_BITS'(s);
    endfunction

endpackage

`default_nettype wire

>>> rtl/hld_ram.sv
`default_nettype none

module hld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/hld_front.sv
`default_nettype none

module hld_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output      logic                           o_ready,
    input  wire logic                           i_action,
    input  wire logic [hld_pkg::HUB_BITS-1:0]   i_hub,
    input  wire logic [hld_pkg::DIST_BITS-1:0]  i_dist_req,
    input  wire logic                           i_last,
    output      logic                           o_q_valid,
    output      hld_pkg::t_qitem                o_q_item,
    input  wire logic                           i_pop
);
    import hld_pkg::*;

    t_qitem                r_mem [QDEPTH];
    logic [QPTR_BITS-1:0]  r_wp;
    logic [QPTR_BITS-1:0]  r_rp;
    logic [QCNT_BITS-1:0]  r_cnt;
    t_qitem                w_item;
    logic                  w_push;
    logic                  w_pop;

    // tag each beat so the back end needs no decode of its own
    always_comb begin
        w_item.hub      = i_hub;
        w_item.hop_dist = i_dist_req;
        w_item.last     = i_last;
        if (!i_action) begin
            w_item.kind = KIND_LOAD;
        end else if (i_last) begin
            w_item.kind = KIND_PROBE_LAST;
        end else begin
            w_item.kind = KIND_PROBE;
        end
    end

    assign o_ready   = (r_cnt != QCNT_BITS'(QDEPTH));
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_pop && o_q_valid;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/hld_back.sv
`default_nettype none

module hld_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire hld_pkg::t_qitem               i_q_item,
    output      logic                          o_pop,
    output      logic                          o_valid,
    input  wire logic                          i_ready,
    output      logic [hld_pkg::SUM_BITS-1:0]  o_distance,
    output      logic                          o_found
);
    import hld_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [HUB_BITS-1:0]   r_hub, n_hub;
    logic [DIST_BITS-1:0]  r_dist, n_dist;
    logic                  r_last, n_last;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [CNT_BITS-1:0]   r_pos, n_pos;
    logic [SUM_BITS-1:0]   r_best, n_best;
    logic                  r_any, n_any;
    logic                  r_done, n_done;
    logic                  r_out_valid, n_out_valid;
    logic [SUM_BITS-1:0]   r_out_dist, n_out_dist;
    logic                  r_out_found, n_out_found;

    logic                  w_we;
    logic [ADDR_BITS-1:0]  w_waddr;
    logic [ADDR_BITS-1:0]  w_raddr;
    logic [ENTRY_BITS-1:0] w_rdata;
    logic [HUB_BITS-1:0]   w_s_hub;
    logic [DIST_BITS-1:0]  w_s_dist;
    logic [CNT_BITS-1:0]   w_eff_cnt;
    logic [CNT_BITS-1:0]   w_pos_inc;
    logic [SUM_BITS-1:0]   w_sum;
    logic                  w_in_range;
    logic                  w_out_free;

    hld_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_LABEL)
    ) u_label (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_q_item.hub, i_q_item.hop_dist}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_s_hub    = w_rdata[ENTRY_BITS-1:DIST_BITS];
    assign w_s_dist   = w_rdata[DIST_BITS-1:0];
    assign w_in_range = (r_pos < r_count);
    assign w_pos_inc  = r_pos + 1'b1;
    assign w_sum      = sat_sum(w_s_dist, r_dist);
    assign w_eff_cnt  = r_done ? '0 : r_count;
    assign w_out_free = !r_out_valid || i_ready;

    assign o_pop      = (r_state == ST_IDLE) && i_q_valid;
    assign o_valid    = r_out_valid;
    assign o_distance = r_out_dist;
    assign o_found    = r_out_found;

    always_comb begin
        n_state     = r_state;
        n_hub       = r_hub;
        n_dist      = r_dist;
        n_last      = r_last;
        n_count     = r_count;
        n_pos       = r_pos;
        n_best      = r_best;
        n_any       = r_any;
        n_done      = r_done;
        n_out_valid = r_out_valid && !i_ready;
        n_out_dist  = r_out_dist;
        n_out_found = r_out_found;
        w_we        = 1'b0;
        w_waddr     = w_eff_cnt[ADDR_BITS-1:0];
        w_raddr     = r_pos[ADDR_BITS-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.kind == KIND_LOAD) begin
                        // a load after a closed label starts a fresh one
                        if (r_done) begin
                            n_pos  = '0;
                            n_best = SUM_MAX;
                            n_any  = 1'b0;
                            n_done = 1'b0;
                        end
                        n_count = w_eff_cnt;
                        if (w_eff_cnt < CNT_BITS'(MAX_LABEL)) begin
                            w_we    = 1'b1;
                            n_count = w_eff_cnt + 1'b1;
                        end
                        if (i_q_item.last) begin
                            n_done = 1'b1;
                        end
                    end else begin
                        n_hub   = i_q_item.hub;
                        n_dist  = i_q_item.hop_dist;
                        n_last  = (i_q_item.kind == KIND_PROBE_LAST);
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                if (w_in_range && (w_s_hub < r_hub)) begin
                    // skip the smaller stored hub and fetch the next one
                    n_pos   = w_pos_inc;
                    w_raddr = w_pos_inc[ADDR_BITS-1:0];
                end else begin
                    if (w_in_range && (w_s_hub == r_hub)) begin
                        if (w_sum < r_best) begin
                            n_best = w_sum;
                        end
                        n_any = 1'b1;
                        n_pos = w_pos_inc;
                    end
                    n_state = r_last ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_dist  = r_any ? r_best : '0;
                    n_out_found = r_any;
                    n_pos       = '0;
                    n_best      = SUM_MAX;
                    n_any       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hub      <= n_hub;
        r_dist     <= n_dist;
        r_last     <= n_last;
        r_out_dist <= n_out_dist;
        r_out_found <= n_out_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_best      <= SUM_MAX;
            r_any       <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_best      <= n_best;
            r_any       <= n_any;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hub_label_distance_query_unit.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_action, i_hub, i_dist_req, i_last
// result    out        o_valid / i_ready  o_distance, o_found
//
// In the back end a load beat writes the label RAM as it is popped; a probe beat
// moves to a compare state that skips each stored hub below it, and a closing
// probe then writes the result register once the result side is free. The single
// read port of the label RAM means one stored entry is compared per cycle.
// Reset is synchronous and active low; the label RAM holds no reset value.
// A two-beat queue in front lets input beats arrive while the back end walks
// the label or a result waits on i_ready.
`default_nettype none

module hub_label_distance_query_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output      logic                          o_ready,
    input  wire logic                          i_action,
    input  wire logic [hld_pkg::HUB_BITS-1:0]  i_hub,
    input  wire logic [hld_pkg::DIST_BITS-1:0] i_dist_req,
    input  wire logic                          i_last,
    output      logic                          o_valid,
    input  wire logic                          i_ready,
    output      logic [hld_pkg::SUM_BITS-1:0]  o_distance,
    output      logic                          o_found
);
    import hld_pkg::*;

    logic    q_valid;
    t_qitem  q_item;
    logic    q_pop;

    // front: classify beats and buffer them
    hld_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_hub      (i_hub),
        .i_dist_req (i_dist_req),
        .i_last     (i_last),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_pop      (q_pop)
    );

    // back: store the source label, walk it for each probe, hold the result
    hld_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_distance (o_distance),
        .o_found    (o_found)
    );

`ifndef NO_ASSERTIONS
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_distance == '0))
        else $error("result without common hub carries a distance");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> q_valid)
        else $error("input stalled with an empty queue");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

// Checks the two-hop hub label distance query unit. Source labels are loaded as
// ascending (hub, distance) beats, target labels are streamed against them, and
// every closing probe is matched against an answer worked out by a behavioral
// merge kept inside this bench. Both sides of the handshake idle at random in
// two mixes, then run flat out.
module testbench;
    import hld_pkg::*;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PROBE = 1'b1;

    localparam logic [HUB_BITS-1:0]  HUB_MAX  = '1;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // a closing probe may skip the whole stored label before it answers
    localparam int DRAIN_CYCLES = 2 * MAX_LABEL + 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SUM_BITS-1:0] distance;
        logic                found;
    } answer_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_action;
    logic [HUB_BITS-1:0]  i_hub;
    logic [DIST_BITS-1:0] i_dist_req;
    logic                 i_last;
    logic                 o_valid;
    logic                 i_ready;
    logic [SUM_BITS-1:0]  o_distance;
    logic                 o_found;

    hub_label_distance_query_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_hub      (i_hub),
        .i_dist_req (i_dist_req),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_distance (o_distance),
        .o_found    (o_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the block's state: the stored source label, the merge
    // pointer and the running minimum of the query in flight.
    logic [HUB_BITS-1:0]  lbl_hub  [MAX_LABEL];
    logic [DIST_BITS-1:0] lbl_dist [MAX_LABEL];
    int                   lbl_count  = 0;
    bit                   lbl_closed = 1'b0;
    int                   walk_pos   = 0;
    logic [SUM_BITS-1:0]  best_total = SUM_MAX;
    bit                   any_common = 1'b0;

    // answers owed by the block, oldest first
    answer_t expected_answers [$];

    int beats_sent    = 0;
    int answers_seen  = 0;
    int answers_found = 0;
    int mismatches    = 0;

    // chance, in percent, that a side idles in a given cycle
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;

    // Advance the shadow label by one beat; return 1 when the beat closes a
    // target list and so owes an answer.
    function automatic bit merge_label_entry(input logic act,
                                             input logic [HUB_BITS-1:0] hub,
                                             input logic [DIST_BITS-1:0] hop_dist,
                                             input logic is_last,
                                             output answer_t ans);
        logic [SUM_BITS:0]   wide;
        logic [SUM_BITS-1:0] total;
        ans = '0;
        if (act == ACT_LOAD) begin
            // a load after a closed label starts a fresh one
            if (lbl_closed) begin
                lbl_count  = 0;
                lbl_closed = 1'b0;
                walk_pos   = 0;
                best_total = SUM_MAX;
                any_common = 1'b0;
            end
            // entries past the label capacity are dropped, but last still closes
            if (lbl_count < MAX_LABEL) begin
                lbl_hub[lbl_count]  = hub;
                lbl_dist[lbl_count] = hop_dist;
                lbl_count++;
            end
            if (is_last) begin
                lbl_closed = 1'b1;
            end
            return 1'b0;
        end
        // skip stored hubs below the probe; a larger stored hub holds the pointer
        while (walk_pos < lbl_count && lbl_hub[walk_pos] < hub) begin
            walk_pos++;
        end
        if (walk_pos < lbl_count && lbl_hub[walk_pos] == hub) begin
            wide  = (SUM_BITS + 1)'(lbl_dist[walk_pos]) + (SUM_BITS + 1)'(hop_dist);
            total = (wide > (SUM_BITS + 1)'(SUM_MAX)) ? SUM_MAX : wide[SUM_BITS-1:0];
            if (total < best_total) begin
                best_total = total;
            end
            any_common = 1'b1;
            walk_pos++;
        end
        if (!is_last) begin
            return 1'b0;
        end
        ans.found    = any_common;
        ans.distance = any_common ? best_total : '0;
        walk_pos     = 0;
        best_total   = SUM_MAX;
        any_common   = 1'b0;
        return 1'b1;
    endfunction

    // Drive one beat at the falling edge and hold it until accepted. Idle
    // cycles drop valid; back-to-back beats keep it high and just swap payload.
    task automatic send_beat(input logic act, input logic [HUB_BITS-1:0] hub,
                             input logic [DIST_BITS-1:0] hop_dist, input logic is_last);
        answer_t ans;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_hub      <= hub;
        i_dist_req <= hop_dist;
        i_last     <= is_last;
        forever begin
            @(posedge i_clk);
            if (o_ready) begin
                break;
            end
        end
        beats_sent++;
        if (merge_label_entry(act, hub, hop_dist, is_last, ans)) begin
            expected_answers = {expected_answers, ans};
        end
    endtask

    // skew distances toward the corners while keeping every bit busy
    function automatic logic [DIST_BITS-1:0] pick_dist();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return '0;
        end else if (roll < 22) begin
            return DIST_MAX;
        end else if (roll < 35) begin
            return DIST_BITS'($urandom_range(255));
        end
        return DIST_BITS'($urandom);
    endfunction

    task automatic note_mismatch(input string what, input logic [SUM_BITS-1:0] want,
                                 input logic [SUM_BITS-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] %s mismatch: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // Result side: check at the rising edge, then pick the next ready at the
    // falling edge.
    initial begin
        answer_t want;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                answers_seen++;
                if (o_found === 1'b1) begin
                    answers_found++;
                end
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] result with nothing owed: distance %h found %b",
                                 $realtime, o_distance, o_found);
                    end
                end else begin
                    want = expected_answers.pop_front();
                    if (o_distance !== want.distance) begin
                        note_mismatch("distance", want.distance, o_distance);
                    end
                    if (o_found !== want.found) begin
                        note_mismatch("found", SUM_BITS'(want.found), SUM_BITS'(o_found));
                    end
                end
            end
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Hand-picked labels: hub and distance extremes, the largest sum, no common
    // hub, skipped and held pointer, probing an open label, then a fresh source.
    task automatic test_directed_cases();
        send_beat(ACT_LOAD, '0,       '0,       1'b0);
        send_beat(ACT_LOAD, 23'd1,    DIST_MAX, 1'b0);
        send_beat(ACT_LOAD, 23'd100,  32'd5,    1'b0);
        send_beat(ACT_LOAD, HUB_MAX,  DIST_MAX, 1'b1);

        // mixed hits and misses, minimum comes from hub 100
        send_beat(ACT_PROBE, '0,      DIST_MAX, 1'b0);
        send_beat(ACT_PROBE, 23'd50,  32'd7,    1'b0);
        send_beat(ACT_PROBE, 23'd100, 32'd3,    1'b0);
        send_beat(ACT_PROBE, HUB_MAX, DIST_MAX, 1'b1);
        // largest possible sum
        send_beat(ACT_PROBE, HUB_MAX, DIST_MAX, 1'b1);
        // zero distance on the lowest hub
        send_beat(ACT_PROBE, '0,      '0,       1'b1);
        // nothing in common
        send_beat(ACT_PROBE, 23'd2,   32'd1,    1'b0);
        send_beat(ACT_PROBE, 23'd99,  32'hA5A5_5A5A, 1'b1);
        // repeated hub: second one meets a larger stored hub and misses
        send_beat(ACT_PROBE, 23'd1,   32'd1,    1'b0);
        send_beat(ACT_PROBE, 23'd1,   32'd1,    1'b0);
        send_beat(ACT_PROBE, 23'd100, DIST_MAX, 1'b1);

        // new source replaces the closed one; probe it before it is closed
        send_beat(ACT_LOAD,  23'd10,  32'd20,   1'b0);
        send_beat(ACT_LOAD,  23'd20,  32'd30,   1'b0);
        send_beat(ACT_PROBE, 23'd20,  32'd1,    1'b1);
        send_beat(ACT_LOAD,  23'd30,  32'd40,   1'b1);
        send_beat(ACT_PROBE, 23'd10,  32'd1,    1'b0);
        send_beat(ACT_PROBE, 23'd30,  32'h5A5A_A5A5, 1'b1);
    endtask

    // Overfill the label: entries past capacity are dropped, yet the closing
    // mark on a dropped entry still closes the label.
    task automatic test_label_overflow();
        for (int i = 0; i < MAX_LABEL + 4; i++) begin
            send_beat(ACT_LOAD, HUB_BITS'(i), DIST_BITS'(i), i == MAX_LABEL + 3);
        end
        send_beat(ACT_PROBE, HUB_BITS'(MAX_LABEL - 1), 32'd5, 1'b0);
        send_beat(ACT_PROBE, HUB_BITS'(MAX_LABEL + 2), 32'd5, 1'b1);
        send_beat(ACT_PROBE, HUB_BITS'(MAX_LABEL + 1), 32'd1, 1'b1);
        // closed by the dropped entry, so this load starts over
        send_beat(ACT_LOAD,  23'd7, 32'd7, 1'b1);
        send_beat(ACT_PROBE, 23'd7, 32'd1, 1'b1);
    endtask

    // Mostly well-formed queries: an ascending source label, then a few target
    // labels that share some of its hubs. The rest is unordered noise.
    task automatic test_random_queries(input int beats);
        logic [HUB_BITS-1:0] src_hubs [$];
        logic [HUB_BITS-1:0] tgt_hubs [$];
        logic [HUB_BITS-1:0] lo;
        int                  start;
        int                  n;
        int                  stride;
        int                  nxt;
        int                  roll;
        start = beats_sent;
        while (beats_sent - start < beats) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 6)) begin
                    send_beat(1'($urandom_range(1)), HUB_BITS'($urandom), pick_dist(),
                              $urandom_range(99) < 25);
                end
                continue;
            end

            // label length: mostly short, sometimes medium, rarely near capacity
            roll = $urandom_range(99);
            if (roll < 70) begin
                n = $urandom_range(1, 8);
            end else if (roll < 98) begin
                n = $urandom_range(9, 40);
            end else begin
                n = $urandom_range(MAX_LABEL - 16, MAX_LABEL);
            end
            roll = $urandom_range(99);
            if (roll < 40) begin
                stride = 2;
            end else if (roll < 75) begin
                stride = 64;
            end else begin
                stride = int'(HUB_MAX) / n;
            end

            src_hubs.delete();
            nxt = ($urandom_range(99) < 10) ? 0 : int'($urandom_range(HUB_MAX));
            for (int i = 0; i < n; i++) begin
                src_hubs = {src_hubs, HUB_BITS'(nxt)};
                nxt = nxt + int'($urandom_range(1, stride));
                if (nxt > int'(HUB_MAX)) begin
                    nxt = int'(HUB_MAX);
                end
            end
            // now and then leave the label open so probes see a partial one
            roll = $urandom_range(99);
            for (int i = 0; i < n; i++) begin
                send_beat(ACT_LOAD, src_hubs[i], pick_dist(), (i == n - 1) && roll < 90);
            end

            repeat ($urandom_range(1, 4)) begin
                tgt_hubs.delete();
                foreach (src_hubs[i]) begin
                    lo = (tgt_hubs.size() != 0) ? tgt_hubs[$] : '0;
                    if (src_hubs[i] > lo && $urandom_range(99) < 30) begin
                        tgt_hubs = {tgt_hubs,
                                    HUB_BITS'($urandom_range(src_hubs[i] - 1, lo))};
                    end
                    if ($urandom_range(99) < 55) begin
                        tgt_hubs = {tgt_hubs, src_hubs[i]};
                    end
                end
                lo = (tgt_hubs.size() != 0) ? tgt_hubs[$] : src_hubs[$];
                if (tgt_hubs.size() == 0 || $urandom_range(99) < 30) begin
                    tgt_hubs = {tgt_hubs, HUB_BITS'($urandom_range(HUB_MAX, lo))};
                end
                foreach (tgt_hubs[i]) begin
                    send_beat(ACT_PROBE, tgt_hubs[i], pick_dist(), i == tgt_hubs.size() - 1);
                end
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_action   = ACT_LOAD;
        i_hub      = '0;
        i_dist_req = '0;
        i_last     = 1'b0;

        snd_idle_pct = 35;
        rcv_idle_pct = 73;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_label_overflow();
        test_random_queries(85);

        snd_idle_pct = 73;
        rcv_idle_pct = 35;
        test_random_queries(85);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_queries(85);

        @(negedge i_clk);
        i_valid <= 1'b0;

        // wait for every owed answer, then give the back end time to show
        // anything extra
        while (expected_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats and %0d answers, %0d of them with a common hub",
                 beats_sent, answers_seen, answers_found);
        $display("idle mixes: sender 35%% / receiver 73%%, then 73%% / 35%%, then none");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
